// ===== rtl/u8n1_pkg.sv =====
// Shared types and constants for the 8N1 half-duplex UART transceiver.
// No dependencies.
package u8n1_pkg;

    localparam int DATA_BITS   = 8;
    localparam int IDX_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int RELOAD_W    = 8;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = RELOAD_W'(160);
    localparam logic [RELOAD_W-1:0] TICK_LAST    = {RELOAD_W{1'b1}};
    localparam logic [IDX_W-1:0]    IDX_DATA_END = IDX_W'(DATA_BITS);
    localparam logic [IDX_W-1:0]    IDX_STOP     = IDX_W'(DATA_BITS + 1);

    typedef struct packed {
        logic              rxd_level;
        logic              tx_request;
        logic [BYTE_W-1:0] tx_data;
    } u8n1_item_t;

    typedef struct packed {
        logic              txd_level;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic              tx_done;
        logic              busy_res;
    } u8n1_result_t;

endpackage

// ===== rtl/uart_8n1_half_duplex_transceiver.sv =====
// Top level of the 8N1 half-duplex UART transceiver: one item per timer tick.
// Depends on u8n1_pkg, u8n1_core and u8n1_out_reg.
// The result of an item is registered and is on the m_ channel in the cycle after it is accepted.
// Throughput: one item per cycle; s_ready drops only while a result waits unread.
// Reset (aresetn low, synchronous): idle, receive mode, line high, bit_reload 160,
// no result pending.
module uart_8n1_half_duplex_transceiver
    import u8n1_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [RELOAD_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_rxd_level,
    input  logic                s_tx_request,
    input  logic [BYTE_W-1:0]   s_tx_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_txd_level,
    output logic                m_rx_valid,
    output logic [BYTE_W-1:0]   m_rx_data,
    output logic                m_tx_done,
    output logic                m_busy_res
);

    u8n1_item_t   item;
    u8n1_result_t core_result;
    u8n1_result_t out_data;
    logic         step;

    assign item.rxd_level  = s_rxd_level;
    assign item.tx_request = s_tx_request;
    assign item.tx_data    = s_tx_data;
    assign step            = s_valid && s_ready;

    u8n1_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (item),
        .result      (core_result)
    );

    u8n1_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .load_data (core_result),
        .can_load  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .data      (out_data)
    );

    assign m_txd_level = out_data.txd_level;
    assign m_rx_valid  = out_data.rx_valid;
    assign m_rx_data   = out_data.rx_data;
    assign m_tx_done   = out_data.tx_done;
    assign m_busy_res  = out_data.busy_res;

endmodule

// ===== rtl/u8n1_core.sv =====
// Transfer state and per-tick next-state logic of the UART transceiver.
// Depends on u8n1_pkg.
module u8n1_core
    import u8n1_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [RELOAD_W-1:0] cfg_wr_data,
    input  logic                step,
    input  u8n1_item_t          item,
    output u8n1_result_t        result
);

    logic [RELOAD_W-1:0]  bit_reload_reg;
    logic [RELOAD_W-1:0]  tick_count_reg, tick_count_next;
    logic                 running_reg, running_next;
    logic                 is_transmit_reg, is_transmit_next;
    logic [IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [DATA_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [DATA_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic                 line_out_reg, line_out_next;
    logic [RELOAD_W:0]    period;
    logic [RELOAD_W-1:0]  half;
    logic [IDX_W-1:0]     idx_inc;
    logic                 valid_w, done_w;

    assign period  = (RELOAD_W+1)'(1 << RELOAD_W) - {1'b0, bit_reload_reg};
    assign half    = (period[RELOAD_W:1] == '0) ? RELOAD_W'(1) : period[RELOAD_W:1];
    assign idx_inc = bit_index_reg + IDX_W'(1);

    always_comb begin
        tick_count_next  = tick_count_reg;
        running_next     = running_reg;
        is_transmit_next = is_transmit_reg;
        bit_index_next   = bit_index_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        line_out_next    = line_out_reg;
        valid_w          = 1'b0;
        done_w           = 1'b0;
        if (!running_reg) begin
            if (item.tx_request) begin
                tx_shift_next    = DATA_BITS'(item.tx_data);
                tick_count_next  = bit_reload_reg;
                line_out_next    = 1'b0;
                bit_index_next   = '0;
                is_transmit_next = 1'b1;
                running_next     = 1'b1;
            end else if (!item.rxd_level) begin
                tick_count_next  = RELOAD_W'(0) - half;
                bit_index_next   = '0;
                is_transmit_next = 1'b0;
                running_next     = 1'b1;
            end
        end else if (tick_count_reg == TICK_LAST) begin
            tick_count_next = bit_reload_reg;
            if (is_transmit_reg) begin
                bit_index_next = idx_inc;
                if (idx_inc <= IDX_DATA_END) begin
                    line_out_next = tx_shift_reg[0];
                    tx_shift_next = tx_shift_reg >> 1;
                end else if (idx_inc == IDX_STOP) begin
                    line_out_next = 1'b1;
                end else begin
                    bit_index_next = '0;
                    running_next   = 1'b0;
                    done_w         = 1'b1;
                end
            end else begin
                if (bit_index_reg == '0) begin
                    if (!item.rxd_level) begin
                        rx_shift_next  = '0;
                        bit_index_next = IDX_W'(1);
                    end else begin
                        running_next = 1'b0;
                    end
                end else if (bit_index_reg <= IDX_DATA_END) begin
                    rx_shift_next  = {item.rxd_level, rx_shift_reg[DATA_BITS-1:1]};
                    bit_index_next = idx_inc;
                end else begin
                    bit_index_next = '0;
                    running_next   = 1'b0;
                    valid_w        = item.rxd_level;
                end
            end
        end else begin
            tick_count_next = tick_count_reg + RELOAD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reload_reg  <= RELOAD_RESET;
            tick_count_reg  <= '0;
            running_reg     <= 1'b0;
            is_transmit_reg <= 1'b0;
            bit_index_reg   <= '0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            line_out_reg    <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                bit_reload_reg <= cfg_wr_data;
            end
            if (step) begin
                tick_count_reg  <= tick_count_next;
                running_reg     <= running_next;
                is_transmit_reg <= is_transmit_next;
                bit_index_reg   <= bit_index_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
                line_out_reg    <= line_out_next;
            end
        end
    end

    assign result.txd_level = line_out_next;
    assign result.rx_valid  = valid_w;
    assign result.rx_data   = BYTE_W'(rx_shift_next);
    assign result.tx_done   = done_w;
    assign result.busy_res  = running_next;

    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> bit_index_reg == '0)
        else $error("bit index nonzero while idle");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> bit_index_reg <= IDX_STOP)
        else $error("bit index past stop bit");

    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (done_w || valid_w) |=> !running_reg)
        else $error("transfer still running after end of frame");

    a_tx_line_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> line_out_reg)
        else $error("transmit line low while idle");

endmodule

// ===== rtl/u8n1_out_reg.sv =====
// Result register that separates the tick input from the result channel.
// Depends on u8n1_pkg.
module u8n1_out_reg
    import u8n1_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  u8n1_result_t load_data,
    output logic         can_load,
    output logic         m_valid,
    input  logic         m_ready,
    output u8n1_result_t data
);

    logic         valid_reg;
    u8n1_result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign data    = data_reg;

endmodule

// ===== sim/uart_tick_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 8N1 UART transceiver: predicts one result per accepted tick item
// and compares it with the m_ channel. Depends on u8n1_pkg.
module uart_tick_checker
    import u8n1_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [RELOAD_W-1:0] cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_rxd_level,
    input  logic                s_tx_request,
    input  logic [BYTE_W-1:0]   s_tx_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_txd_level,
    input  logic                m_rx_valid,
    input  logic [BYTE_W-1:0]   m_rx_data,
    input  logic                m_tx_done,
    input  logic                m_busy_res,
    output int                  errors,
    output int                  pending,
    output logic                line_busy
);

    logic [RELOAD_W-1:0] reload_q;
    logic [RELOAD_W-1:0] tmr;
    logic                active;
    logic                tx_mode;
    logic [IDX_W-1:0]    bit_pos;
    logic [BYTE_W-1:0]   tx_sr;
    logic [BYTE_W-1:0]   rx_sr;
    logic                txd_q;

    u8n1_result_t        line_q[$];

    initial errors = 0;

    task automatic advance_tick(input u8n1_item_t it, output u8n1_result_t r);
        logic [RELOAD_W:0]   span;
        logic [RELOAD_W-1:0] half;
        logic                got_byte;
        logic                sent;
        got_byte = 1'b0;
        sent     = 1'b0;
        if (!active) begin
            if (it.tx_request) begin
                tx_sr   = it.tx_data;
                tmr     = reload_q;
                txd_q   = 1'b0;
                bit_pos = '0;
                tx_mode = 1'b1;
                active  = 1'b1;
            end else if (!it.rxd_level) begin
                span = 9'd256 - reload_q;
                half = span[RELOAD_W:1];
                if (half == '0) half = 8'd1;
                span    = 9'd256 - half;
                tmr     = span[RELOAD_W-1:0];
                bit_pos = '0;
                tx_mode = 1'b0;
                active  = 1'b1;
            end
        end else if (tmr != TICK_LAST) begin
            tmr = tmr + 8'd1;
        end else begin
            tmr = reload_q;
            if (tx_mode) begin
                bit_pos = bit_pos + 4'd1;
                if (bit_pos <= IDX_DATA_END) begin
                    txd_q = tx_sr[0];
                    tx_sr = tx_sr >> 1;
                end else if (bit_pos == IDX_STOP) begin
                    txd_q = 1'b1;
                end else begin
                    bit_pos = '0;
                    active  = 1'b0;
                    sent    = 1'b1;
                end
            end else if (bit_pos == '0) begin
                if (!it.rxd_level) begin
                    rx_sr   = '0;
                    bit_pos = 4'd1;
                end else begin
                    active = 1'b0;
                end
            end else if (bit_pos <= IDX_DATA_END) begin
                rx_sr   = {it.rxd_level, rx_sr[BYTE_W-1:1]};
                bit_pos = bit_pos + 4'd1;
            end else begin
                bit_pos  = '0;
                active   = 1'b0;
                got_byte = it.rxd_level;
            end
        end
        r.txd_level = txd_q;
        r.rx_valid  = got_byte;
        r.rx_data   = rx_sr;
        r.tx_done   = sent;
        r.busy_res  = active;
    endtask

    task automatic cmp(input string fld, input logic [BYTE_W-1:0] want_v,
                       input logic [BYTE_W-1:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $error("%s: expected %0h, got %0h", fld, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        u8n1_item_t   it;
        u8n1_result_t want;
        if (!aresetn) begin
            reload_q = RELOAD_RESET;
            tmr      = '0;
            active   = 1'b0;
            tx_mode  = 1'b0;
            bit_pos  = '0;
            tx_sr    = '0;
            rx_sr    = '0;
            txd_q    = 1'b1;
            line_q.delete();
        end else begin
            if (cfg_wr_en) reload_q = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (line_q.size() == 0) begin
                    errors++;
                    $error("result with no item outstanding");
                end else begin
                    want = line_q.pop_front();
                    cmp("txd_level", BYTE_W'(want.txd_level), BYTE_W'(m_txd_level));
                    cmp("rx_valid", BYTE_W'(want.rx_valid), BYTE_W'(m_rx_valid));
                    cmp("rx_data", want.rx_data, m_rx_data);
                    cmp("tx_done", BYTE_W'(want.tx_done), BYTE_W'(m_tx_done));
                    cmp("busy_res", BYTE_W'(want.busy_res), BYTE_W'(m_busy_res));
                end
            end
            if (s_valid && s_ready) begin
                it.rxd_level  = s_rxd_level;
                it.tx_request = s_tx_request;
                it.tx_data    = s_tx_data;
                advance_tick(it, want);
                line_q.push_back(want);
            end
        end
        pending   = line_q.size();
        line_busy = active;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the UART transceiver testbench: clock, reset, serial frame stimulus,
// bit period settings and verdict. Depends on u8n1_pkg, uart_tick_checker and the RTL.
module tb;
    import u8n1_pkg::*;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [RELOAD_W-1:0] cfg_wr_data  = '0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic                s_rxd_level  = 1'b1;
    logic                s_tx_request = 1'b0;
    logic [BYTE_W-1:0]   s_tx_data    = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic                m_txd_level;
    logic                m_rx_valid;
    logic [BYTE_W-1:0]   m_rx_data;
    logic                m_tx_done;
    logic                m_busy_res;

    int                  errors;
    int                  pending;
    logic                line_busy;

    int unsigned         s_idle_pct = 23;
    int unsigned         m_idle_pct = 23;
    bit                  hold_go    = 1'b0;
    int unsigned         tick_total = 0;

    uart_8n1_half_duplex_transceiver dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rxd_level (s_rxd_level),
        .s_tx_request(s_tx_request),
        .s_tx_data   (s_tx_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_txd_level (m_txd_level),
        .m_rx_valid  (m_rx_valid),
        .m_rx_data   (m_rx_data),
        .m_tx_done   (m_tx_done),
        .m_busy_res  (m_busy_res)
    );

    uart_tick_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rxd_level (s_rxd_level),
        .s_tx_request(s_tx_request),
        .s_tx_data   (s_tx_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_txd_level (m_txd_level),
        .m_rx_valid  (m_rx_valid),
        .m_rx_data   (m_rx_data),
        .m_tx_done   (m_tx_done),
        .m_busy_res  (m_busy_res),
        .errors      (errors),
        .pending     (pending),
        .line_busy   (line_busy)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side; one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    task automatic send_tick(input logic rxd, input logic req, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_rxd_level  <= rxd;
        s_tx_request <= req;
        s_tx_data    <= data;
        do @(posedge aclk); while (!s_ready);
        tick_total++;
    endtask

    // feed idle-line items until every result is back and the line is quiet
    task automatic settle();
        s_valid <= 1'b0;
        forever begin
            @(negedge aclk);
            if (pending == 0) begin
                if (!line_busy) break;
                @(posedge aclk);
                send_tick(1'b1, 1'b0, 8'($urandom));
                s_valid <= 1'b0;
            end
        end
        @(posedge aclk);
    endtask

    task automatic write_reload(input logic [RELOAD_W-1:0] v);
        settle();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // start bit is stretched to 2 ticks at period 1 so the start check lands on it
    task automatic send_frame(input int unsigned per, input logic [BYTE_W-1:0] b,
                              input logic stop_lvl);
        int unsigned half;
        int unsigned lead;
        int unsigned stop_len;
        half     = (per >> 1 == 0) ? 1 : per >> 1;
        lead     = (per == 1) ? 2 : per;
        stop_len = stop_lvl ? per : ((per == 1) ? 1 : half + 1);
        repeat (lead) send_tick(1'b0, 1'b0, 8'($urandom));
        for (int i = 0; i < BYTE_W; i++) begin
            repeat (per) send_tick(b[i], 1'b0, 8'($urandom));
        end
        repeat (stop_len) send_tick(stop_lvl, 1'b0, 8'($urandom));
        send_tick(1'b1, 1'b0, 8'($urandom));
    endtask

    task automatic send_glitch(input int unsigned per);
        int unsigned half;
        int unsigned low_len;
        half    = (per >> 1 == 0) ? 1 : per >> 1;
        low_len = $urandom_range(half, 1);
        repeat (low_len) send_tick(1'b0, 1'b0, 8'($urandom));
        repeat (half - low_len + 2) send_tick(1'b1, 1'b0, 8'($urandom));
    endtask

    // requests and line levels during the transfer are noise for the busy block
    task automatic send_tx(input int unsigned per, input logic [BYTE_W-1:0] data);
        send_tick(1'($urandom_range(1)), 1'b1, data);
        repeat (10 * per) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
        end
        send_tick(1'b1, 1'b0, 8'($urandom));
    endtask

    task automatic random_phase(input logic [RELOAD_W-1:0] reload, input int unsigned n,
                                input bit squeeze);
        int unsigned per;
        int unsigned stop_at;
        int unsigned pick;
        per = 256 - reload;
        write_reload(reload);
        if (squeeze) hold_go = 1'b1;
        stop_at = tick_total + n;
        while (tick_total < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_frame(per, 8'($urandom), 1'b1);
            end else if (pick < 55) begin
                send_frame(per, 8'($urandom), 1'b0);
            end else if (pick < 75) begin
                send_tx(per, 8'($urandom));
            end else if (pick < 85) begin
                send_glitch(per);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_tick(1'($urandom_range(1)), ($urandom_range(9) == 0), 8'($urandom));
                end
            end
            repeat ($urandom_range(3)) send_tick(1'b1, 1'b0, 8'($urandom));
        end
    endtask

    initial begin
        logic [RELOAD_W-1:0] rl;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset bit period: false start
        send_glitch(256 - RELOAD_RESET);

        // fastest period
        write_reload(8'd255);
        send_tick(1'b0, 1'b1, 8'hFF);
        repeat (10) send_tick(1'b1, 1'b1, 8'h00);
        send_tick(1'b1, 1'b0, 8'h00);
        send_frame(1, 8'h00, 1'b0);
        send_frame(1, 8'hFF, 1'b1);
        send_glitch(1);

        // slowest period: false start only
        write_reload(8'd0);
        send_glitch(256);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: rl = 8'd255;
                1: rl = 8'd254;
                2: rl = 8'd253;
                3: rl = 8'd252;
                4: rl = 8'd250;
                5: rl = 8'd248;
                default: rl = 8'($urandom_range(255, 240));
            endcase
            s_idle_pct = (ph == 1) ? 0 : 23;
            m_idle_pct = (ph == 1) ? 0 : 23;
            random_phase(rl, (ph == 1) ? 200 : 90, ph == 2);
        end

        settle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/u8n1_pkg.sv
rtl/u8n1_core.sv
rtl/u8n1_out_reg.sv
rtl/uart_8n1_half_duplex_transceiver.sv
sim/uart_tick_checker.sv
sim/tb.sv
